@@ rtl/teuo_pkg.sv @@
// Shared types and codes for the elementwise unary operator.
// Used by the top level and teuo_fpround of the RTL, and by the testbench; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package teuo_pkg;

    typedef enum logic [1:0] {
        OP_RELU   = 2'd0,
        OP_SQUARE = 2'd1,
        OP_ABS    = 2'd2,
        OP_PASS   = 2'd3
    } op_t;

    // Upper two bits of the element type code.
    typedef enum logic [1:0] {
        KIND_UINT  = 2'd0,
        KIND_SINT  = 2'd1,
        KIND_FLOAT = 2'd2
    } kind_t;

    // Lower two bits of the element type code.
    typedef enum logic [1:0] {
        WID_8  = 2'd0,
        WID_16 = 2'd1,
        WID_32 = 2'd2,
        WID_64 = 2'd3
    } wid_t;

    localparam logic [3:0] DT_LAST = 4'd11;

    localparam logic       CFG_OPERATION = 1'b0;
    localparam logic       CFG_ELEM_TYPE = 1'b1;

    // Where a word's result comes from at the output stage.
    typedef enum logic [1:0] {
        ROUTE_PLAIN = 2'd0,
        ROUTE_INT   = 2'd1,
        ROUTE_FP    = 2'd2
    } route_t;

    typedef struct packed {
        route_t      route;
        logic        fp64;
        logic [10:0] exp;
        logic [63:0] mask;
        logic [63:0] plain;
    } stage_t;

    localparam logic signed [13:0] BIAS64 = 14'sd1023;
    localparam logic signed [13:0] BIAS32 = 14'sd127;
    localparam logic signed [13:0] EMAX64 = 14'sd2047;
    localparam logic signed [13:0] EMAX32 = 14'sd255;

endpackage

`default_nettype wire

@@ rtl/teuo_if.sv @@
// Valid/ready channel interfaces for the elementwise unary operator.
// Element channel in, result channel out; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface teuo_elem_if;
    logic        valid;
    logic        ready;
    logic [63:0] element;

    modport source (output valid, output element, input ready);
    modport sink   (input valid, input element, output ready);
endinterface

interface teuo_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

@@ rtl/tensor_elementwise_unary_op.sv @@
// Top level of the elementwise unary operator (ReLU, square, absolute value).
// Depends on teuo_pkg, teuo_if, teuo_mult and teuo_fpround.
//
// Takes one 64-bit word per cycle unless the output stalls, and returns one
// result word per input word. The result word passes four registers before it
// is presented: input register, partial products, product sum, result
// register. The whole pipeline advances whenever the result register is empty
// or being taken, so the sustained rate is one word per clock; the 64-bit
// square (three 32x32 products plus a 128-bit sum) sets the depth. Write the
// operation and element type registers only while no word is in flight.
`timescale 1ns / 1ps
`default_nettype none

module tensor_elementwise_unary_op
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    teuo_elem_if.sink          feed,
    teuo_result_if.source      drain,
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic [3:0]    cfg_data
);
    import teuo_pkg::*;

    op_t          op_reg;
    logic [3:0]   dt_reg;

    logic         adv;
    logic         v1_reg, v2_reg, v3_reg, vo_reg;
    logic [63:0]  elem_reg;
    op_t          op1_reg;
    logic [3:0]   dt1_reg;
    stage_t       s1_next;
    stage_t       s2_reg, s3_reg;
    logic [63:0]  res_reg, res_next;

    wid_t         wsel;
    kind_t        kind;
    logic [63:0]  x;
    logic         neg;
    logic         fp64;
    logic         exp_max;
    logic         exp_zero;
    logic         frac_nz;
    logic [52:0]  m53;
    logic [31:0]  op_hi, op_lo;
    logic [127:0] sum;
    logic [63:0]  fp_res;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= OP_RELU;
            dt_reg <= 4'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OPERATION: op_reg <= op_t'(cfg_data[1:0]);
                CFG_ELEM_TYPE: dt_reg <= cfg_data;
                default:       op_reg <= op_reg;
            endcase
        end
    end

    assign adv        = !vo_reg || drain.ready;
    assign feed.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= feed.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            elem_reg <= feed.element;
            op1_reg  <= op_reg;
            dt1_reg  <= dt_reg;
            s2_reg   <= s1_next;
            s3_reg   <= s2_reg;
            res_reg  <= res_next;
        end
    end

    // decode and the operations that need no multiply
    always_comb
    begin
        wsel = wid_t'(dt1_reg[1:0]);
        kind = kind_t'(dt1_reg[3:2]);
        s1_next = '0;
        case (wsel)
            WID_8:   s1_next.mask = 64'h0000_0000_0000_00FF;
            WID_16:  s1_next.mask = 64'h0000_0000_0000_FFFF;
            WID_32:  s1_next.mask = 64'h0000_0000_FFFF_FFFF;
            default: s1_next.mask = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        x = elem_reg & s1_next.mask;
        case (wsel)
            WID_8:   neg = x[7];
            WID_16:  neg = x[15];
            WID_32:  neg = x[31];
            default: neg = x[63];
        endcase
        fp64     = (wsel == WID_64);
        exp_max  = fp64 ? (&x[62:52]) : (&x[30:23]);
        exp_zero = fp64 ? !(|x[62:52]) : !(|x[30:23]);
        frac_nz  = fp64 ? (|x[51:0]) : (|x[22:0]);
        m53      = fp64 ? {1'b1, x[51:0]} : {1'b1, x[22:0], 29'b0};

        s1_next.fp64  = fp64;
        s1_next.exp   = fp64 ? x[62:52] : {3'b0, x[30:23]};
        s1_next.route = ROUTE_PLAIN;
        s1_next.plain = x;

        if (dt1_reg > DT_LAST)
        begin
            s1_next.mask  = 64'hFFFF_FFFF_FFFF_FFFF;
            s1_next.plain = elem_reg;
        end
        else
        begin
            case (op1_reg)
                OP_RELU:
                begin
                    if (kind != KIND_UINT && neg)
                        s1_next.plain = 64'd0;
                end
                OP_SQUARE:
                begin
                    if (kind != KIND_FLOAT)
                        s1_next.route = ROUTE_INT;
                    else if (wsel == WID_32 || wsel == WID_64)
                    begin
                        if (exp_max && frac_nz)
                            s1_next.plain = x | (fp64 ? 64'h0008_0000_0000_0000
                                                      : 64'h0000_0000_0040_0000);
                        else if (exp_max)
                            s1_next.plain = fp64 ? 64'h7FF0_0000_0000_0000
                                                 : 64'h0000_0000_7F80_0000;
                        else if (exp_zero)
                            s1_next.plain = 64'd0;  // tiny squares underflow to +0
                        else
                            s1_next.route = ROUTE_FP;
                    end
                end
                OP_ABS:
                begin
                    if (kind == KIND_SINT && neg)
                        s1_next.plain = (64'd0 - x) & s1_next.mask;
                    else if (kind == KIND_FLOAT && (wsel == WID_32 || wsel == WID_64))
                        s1_next.plain = x & (fp64 ? 64'h7FFF_FFFF_FFFF_FFFF
                                                  : 64'h0000_0000_7FFF_FFFF);
                end
                default:
                begin
                    s1_next.plain = x;
                end
            endcase
        end

        op_hi = (kind == KIND_FLOAT) ? {11'b0, m53[52:32]} : x[63:32];
        op_lo = (kind == KIND_FLOAT) ? m53[31:0] : x[31:0];
    end

    teuo_mult u_mult
    (
        .clk (clk),
        .en  (adv),
        .hi  (op_hi),
        .lo  (op_lo),
        .sum (sum)
    );

    teuo_fpround u_round
    (
        .prod   (sum[105:0]),
        .fp64   (s3_reg.fp64),
        .exp    (s3_reg.exp),
        .result (fp_res)
    );

    always_comb
    begin
        case (s3_reg.route)
            ROUTE_INT: res_next = sum[63:0] & s3_reg.mask;
            ROUTE_FP:  res_next = fp_res;
            default:   res_next = s3_reg.plain;
        endcase
    end

    assign drain.valid  = vo_reg;
    assign drain.result = res_reg;

endmodule

`default_nettype wire

@@ rtl/teuo_mult.sv @@
// Two-stage squaring multiplier: three 32x32 partial products, then their sum.
// Depends on nothing outside the file.
`timescale 1ns / 1ps
`default_nettype none

module teuo_mult
(
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [31:0]  hi,
    input  wire logic [31:0]  lo,
    output logic      [127:0] sum
);

    logic [63:0]  ll_reg;
    logic [63:0]  hl_reg;
    logic [63:0]  hh_reg;
    logic [127:0] sum_reg;
    logic [127:0] sum_next;

    // (hi*2^32 + lo)^2 = hh*2^64 + 2*hl*2^32 + ll
    assign sum_next = {hh_reg, 64'b0} + {31'b0, hl_reg, 33'b0} + {64'b0, ll_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg  <= 64'(lo) * 64'(lo);
            hl_reg  <= 64'(hi) * 64'(lo);
            hh_reg  <= 64'(hi) * 64'(hi);
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

@@ rtl/teuo_fpround.sv @@
// Normalize and round a squared float mantissa into float32 or float64.
// Uses teuo_pkg for the exponent constants.
`timescale 1ns / 1ps
`default_nettype none

module teuo_fpround
(
    input  wire logic [105:0] prod,
    input  wire logic         fp64,
    input  wire logic [10:0]  exp,
    output logic      [63:0]  result
);
    import teuo_pkg::*;

    logic               top;
    logic [105:0]       norm;
    logic signed [13:0] eb;
    logic signed [13:0] shift_s;
    logic [63:0]        keep;
    logic [63:0]        kept;
    logic               sticky;
    logic [10:0]        exp_f;
    logic [52:0]        mant64;
    logic [23:0]        mant32;
    logic               up;
    logic [62:0]        field64;
    logic [30:0]        field32;

    always_comb
    begin
        top     = prod[105];
        norm    = top ? prod : {prod[104:0], 1'b0};
        eb      = $signed({2'b0, exp, 1'b0}) - (fp64 ? BIAS64 : BIAS32)
                  + $signed({13'b0, top});
        keep    = norm[105:42];
        sticky  = |norm[41:0];
        kept    = keep;
        exp_f   = 11'd0;
        shift_s = 14'sd1 - eb;
        if (eb > 14'sd0)
        begin
            exp_f = eb[10:0];
        end
        else if (shift_s >= 14'sd64)
        begin
            kept   = 64'd0;
            sticky = 1'b1;
        end
        else
        begin
            // subnormal: shift right, fold the dropped bits into sticky
            kept   = keep >> shift_s[5:0];
            sticky = sticky | (|(keep & ~(~64'd0 << shift_s[5:0])));
        end

        mant64  = kept[63:11];
        mant32  = kept[63:40];
        field64 = 63'd0;
        field32 = 31'd0;
        up      = 1'b0;
        result  = 64'd0;
        if (fp64)
        begin
            up      = kept[10] & (sticky | (|kept[9:0]) | mant64[0]);
            field64 = {exp_f, mant64[51:0]} + {62'd0, up};
            result  = (eb >= EMAX64) ? 64'h7FF0_0000_0000_0000 : {1'b0, field64};
        end
        else
        begin
            up      = kept[39] & (sticky | (|kept[38:0]) | mant32[0]);
            field32 = {exp_f[7:0], mant32[22:0]} + {30'd0, up};
            result  = (eb >= EMAX32) ? 64'h0000_0000_7F80_0000 : {33'd0, field32};
        end
    end

endmodule

`default_nettype wire

@@ rtl/teuo_checker.sv @@
// Port-level checks for the elementwise unary operator, bound to the top level.
// Depends on tensor_elementwise_unary_op being elaborated.
`timescale 1ns / 1ps
`default_nettype none

module teuo_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [63:0] result
);

    logic [2:0] pend_reg;
    logic [2:0] pend_next;
    logic       in_take;
    logic       out_take;

    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_take && !out_take)
            pend_next = pend_reg + 3'd1;
        else if (out_take && !in_take)
            pend_next = pend_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 3'd0;
        else
            pend_reg <= pend_next;
    end

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result))
        else $error("result word changed while stalled");

    // never more words in flight than pipeline stages
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd4)
        else $error("more than four words in flight");

    // no result word without an accepted input word
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 3'd0)
        else $error("result word with nothing pending");

    // with no result word held at the output, input is ready
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind tensor_elementwise_unary_op teuo_checker u_teuo_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (feed.valid),
    .in_ready  (feed.ready),
    .out_valid (drain.valid),
    .out_ready (drain.ready),
    .result    (drain.result)
);

`default_nettype wire

@@ dv/tb_tensor_elementwise_unary_op.sv @@
// Self-checking testbench for tensor_elementwise_unary_op.
// Depends on teuo_pkg and teuo_if; drives random element streams under
// every operation and element type and checks each result against a local model.
`timescale 1ns / 1ps

module tb_tensor_elementwise_unary_op;
    import teuo_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 1650;

    typedef struct {
        op_t         op;
        logic [3:0]  dt;
        logic [63:0] elem;
    } elem_item_t;

    logic clk;
    logic rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [3:0] cfg_data;

    teuo_elem_if   feed_bus ();
    teuo_result_if drain_bus ();

    tensor_elementwise_unary_op dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .feed      (feed_bus.sink),
        .drain     (drain_bus.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    elem_item_t  pending_elems[$];
    logic [63:0] expected_results[$];
    op_t         cur_op;
    logic [3:0]  cur_dt;
    int          errors;
    int          feed_wait;
    int          drain_wait;
    int          idle_cycles;
    bit          calm;

    always #5 clk = ~clk;

    // Square of a float32 or float64 with round to nearest even.
    function automatic logic [63:0] float_square(logic [63:0] x, bit dbl);
        int mw, emax, bias, e, p, be, be_eff, sh;
        logic [63:0]  m;
        logic [127:0] prod, r, bits;
        logic         half, sticky;
        mw   = dbl ? 52 : 23;
        emax = dbl ? 2047 : 255;
        bias = dbl ? 1023 : 127;
        e = int'((x >> mw) & 64'(emax));
        m = x & ((64'd1 << mw) - 64'd1);
        if (e == emax)
        begin
            if (m != 0)
                return x | (64'd1 << (mw - 1));
            return 64'(emax) << mw;
        end
        if (e == 0 && m == 0)
            return 64'd0;
        if (e == 0)
            e = 1;
        else
            m = m | (64'd1 << mw);
        prod = 128'(m) * 128'(m);
        p = 0;
        for (int i = 0; i < 128; i++)
            if (prod[i])
                p = i;
        be = p + 2 * (e - bias - mw) + bias;
        be_eff = (be < 1) ? 1 : be;
        sh = p - mw + (be_eff - be);
        if (sh <= 0)
            r = prod << (-sh);
        else if (sh > 127)
            r = 128'd0;
        else
        begin
            r = prod >> sh;
            half = prod[sh - 1];
            sticky = (prod & ((128'd1 << (sh - 1)) - 128'd1)) != 0;
            if (half && (sticky || r[0]))
                r = r + 128'd1;
        end
        bits = (128'(be_eff - 1) << mw) + r;
        if (bits >= (128'(emax) << mw))
            bits = 128'(emax) << mw;
        return bits[63:0];
    endfunction

    function automatic logic [63:0] unary_result(op_t op, logic [3:0] dt, logic [63:0] elem);
        int          w;
        kind_t       kind;
        logic [63:0] mask, x, r;
        logic        neg;
        if (dt > DT_LAST)
            return elem;
        w    = 8 << dt[1:0];
        kind = kind_t'(dt[3:2]);
        mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
        x    = elem & mask;
        neg  = x[w - 1];
        r    = x;
        case (op)
            OP_RELU:
                if (kind != KIND_UINT && neg)
                    r = 64'd0;
            OP_SQUARE:
                if (kind != KIND_FLOAT)
                    r = (x * x) & mask;
                else if (w == 32)
                    r = float_square(x, 1'b0);
                else if (w == 64)
                    r = float_square(x, 1'b1);
            OP_ABS:
                if (kind == KIND_SINT)
                begin
                    if (neg)
                        r = (64'd0 - x) & mask;
                end
                else if (kind == KIND_FLOAT && w >= 32)
                    r = x & ~(64'd1 << (w - 1));
            default: ;
        endcase
        return r & mask;
    endfunction

    function automatic logic [63:0] random_element(logic [3:0] dt);
        int          w, mw, ew;
        logic [63:0] mask, v, expo, mant;
        w    = 8 << dt[1:0];
        mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
        mw   = (w == 64) ? 52 : (w == 32) ? 23 : (w == 16) ? 10 : 3;
        ew   = w - 1 - mw;
        case ($urandom_range(0, 4))
            0: v = {$urandom, $urandom};
            1:
            begin
                v = 64'($urandom_range(0, 300));
                if ($urandom_range(0, 1))
                    v = 64'd0 - v;
            end
            2:
                case ($urandom_range(0, 4))
                    0: v = 64'd0;
                    1: v = '1;
                    2: v = 64'd1 << (w - 1);
                    3: v = (64'd1 << (w - 1)) - 64'd1;
                    default: v = 64'd1;
                endcase
            default:
            begin
                case ($urandom_range(0, 5))
                    0: expo = 64'd0;
                    1: expo = 64'd1;
                    2: expo = (64'd1 << ew) - 64'd1;
                    3: expo = (64'd1 << ew) - 64'd2;
                    4: expo = ((64'd1 << (ew - 1)) - 64'd1) + 64'($urandom_range(0, 6)) -
                              64'd3;
                    default: expo = 64'($urandom);
                endcase
                case ($urandom_range(0, 4))
                    0: mant = 64'd0;
                    1: mant = 64'd1;
                    2: mant = '1;
                    3: mant = 64'd1 << (mw - 1);
                    default: mant = {$urandom, $urandom};
                endcase
                v = ((expo & ((64'd1 << ew) - 64'd1)) << mw) |
                    (mant & ((64'd1 << mw) - 64'd1)) |
                    (64'($urandom_range(0, 1)) << (w - 1));
            end
        endcase
        v = v & mask;
        if ($urandom_range(0, 1))
            v = v | ({$urandom, $urandom} & ~mask);
        return v;
    endfunction

    function automatic int draw_wait();
        if (calm)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    task automatic report(string what, logic [63:0] want, logic [63:0] got);
        $display("ERROR %0t: %s: expected %h, got %h", $realtime, what, want, got);
        errors++;
    endtask

    task automatic wait_idle();
        while (pending_elems.size() != 0 || feed_bus.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic index, logic [3:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Reconfigure only once the pipeline has fully drained.
    task automatic queue_elem(op_t op, logic [3:0] dt, logic [63:0] elem);
        elem_item_t it;
        if (op != cur_op || dt != cur_dt)
        begin
            wait_idle();
            calm = ($urandom_range(0, 3) == 0);
            if (op != cur_op)
                write_reg(CFG_OPERATION, 4'(op));
            if (dt != cur_dt)
                write_reg(CFG_ELEM_TYPE, dt);
            cur_op = op;
            cur_dt = dt;
        end
        it.op   = op;
        it.dt   = dt;
        it.elem = elem;
        pending_elems.push_back(it);
    endtask

    // Driver: present one word per item, after a drawn gap.
    always @(posedge clk)
    begin
        elem_item_t it;
        if (rst_n)
        begin
            if (feed_bus.valid && feed_bus.ready)
                expected_results.push_back(unary_result(cur_op, cur_dt, feed_bus.element));
            if (feed_bus.valid && !feed_bus.ready)
                ;
            else if (feed_wait > 0)
            begin
                feed_wait--;
                feed_bus.valid <= 1'b0;
            end
            else if (pending_elems.size() != 0)
            begin
                it = pending_elems.pop_front();
                feed_bus.valid   <= 1'b1;
                feed_bus.element <= it.elem;
                feed_wait = draw_wait();
            end
            else
                feed_bus.valid <= 1'b0;
        end
    end

    // Monitor: compare each taken word with the oldest expectation.
    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n)
        begin
            if (drain_bus.valid && drain_bus.ready)
            begin
                if (expected_results.size() == 0)
                    report("unexpected result", 64'd0, drain_bus.result);
                else
                begin
                    want = expected_results.pop_front();
                    if (drain_bus.result !== want)
                        report("result", want, drain_bus.result);
                end
                drain_wait = draw_wait();
            end
            else if (drain_wait > 0)
                drain_wait--;
            drain_bus.ready <= (drain_wait == 0);
        end
    end

    always @(posedge clk)
    begin
        if ((feed_bus.valid && feed_bus.ready) || (drain_bus.valid && drain_bus.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tensor_elementwise_unary_op: mismatch");
            $finish;
        end
    end

    initial
    begin
        int          sent, run;
        op_t         op;
        logic [3:0]  dt;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = 4'd0;
        feed_bus.valid = 1'b0;
        feed_bus.element = 64'd0;
        drain_bus.ready = 1'b0;
        cur_op = OP_RELU;
        cur_dt = 4'd0;
        errors = 0;
        feed_wait = 0;
        drain_wait = 0;
        idle_cycles = 0;
        calm = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, ignored upper bits, unknown codes, float specials.
        queue_elem(OP_RELU, {KIND_UINT, WID_8}, 64'hFFFF_FFFF_FFFF_FF80);
        queue_elem(OP_RELU, {KIND_SINT, WID_16}, 64'h0000_0000_0000_8000);
        queue_elem(OP_RELU, {KIND_SINT, WID_16}, 64'hFFFF_FFFF_FFFF_7FFF);
        queue_elem(OP_RELU, {KIND_FLOAT, WID_16}, 64'h0000_0000_0000_BC00);
        queue_elem(OP_RELU, {KIND_SINT, WID_64}, 64'h8000_0000_0000_0000);
        queue_elem(OP_SQUARE, {KIND_UINT, WID_8}, 64'h0000_0000_0000_00FF);
        queue_elem(OP_SQUARE, {KIND_UINT, WID_64}, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_elem(OP_SQUARE, {KIND_FLOAT, WID_8}, 64'h0000_0000_0000_00F3);
        queue_elem(OP_SQUARE, {KIND_FLOAT, WID_32}, 64'h0000_0000_7FA0_0000);
        queue_elem(OP_SQUARE, {KIND_FLOAT, WID_32}, 64'h0000_0000_FF80_0000);
        queue_elem(OP_SQUARE, {KIND_FLOAT, WID_32}, 64'h0000_0000_7F7F_FFFF);
        queue_elem(OP_SQUARE, {KIND_FLOAT, WID_32}, 64'hABCD_0000_0000_0001);
        queue_elem(OP_SQUARE, {KIND_FLOAT, WID_32}, 64'h0000_0000_1F80_0001);
        queue_elem(OP_SQUARE, {KIND_FLOAT, WID_64}, 64'hFFF0_0000_0000_0001);
        queue_elem(OP_SQUARE, {KIND_FLOAT, WID_64}, 64'h3FF8_0000_0000_0000);
        queue_elem(OP_SQUARE, {KIND_FLOAT, WID_64}, 64'h7FEF_FFFF_FFFF_FFFF);
        queue_elem(OP_ABS, {KIND_SINT, WID_8}, 64'h0000_0000_0000_0080);
        queue_elem(OP_ABS, {KIND_SINT, WID_64}, 64'h8000_0000_0000_0000);
        queue_elem(OP_ABS, {KIND_SINT, WID_32}, 64'h1234_5678_FFFF_FFFF);
        queue_elem(OP_ABS, {KIND_FLOAT, WID_64}, 64'hFFF8_0000_0000_0000);
        queue_elem(OP_ABS, {KIND_FLOAT, WID_16}, 64'h0000_0000_0000_FC00);
        queue_elem(OP_PASS, {KIND_SINT, WID_32}, 64'hDEAD_BEEF_8765_4321);
        queue_elem(OP_PASS, 4'd15, 64'hDEAD_BEEF_8765_4321);
        queue_elem(OP_RELU, 4'd12, 64'hFFFF_FFFF_FFFF_FFFF);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            op = op_t'(($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2));
            dt = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(12, 15)
                                                 : $urandom_range(0, 11));
            run = $urandom_range(10, 60);
            for (int i = 0; i < run; i++)
                queue_elem(op, dt, random_element(dt));
            sent += run;
        end
        wait_idle();

        if (errors == 0)
            $display("tensor_elementwise_unary_op: match");
        else
            $display("tensor_elementwise_unary_op: mismatch");
        $finish;
    end

endmodule
